// ----- rtl/wnb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnb_pkg : shared constants and types for the wall normal basis core
// Fixed field widths of the request and response channels.
// ----------------------------------------------------------------------------
package wnb_pkg;

   // request field width (unsigned aperture fraction)
   localparam int unsigned IN_W  = 17;
   // response field widths
   localparam int unsigned NRM_W = 18;
   localparam int unsigned TAN_W = 19;
   // magnitude of one difference, its square, and the sum of three squares
   localparam int unsigned AD_W  = 17;
   localparam int unsigned SQ_W  = 34;
   localparam int unsigned SUM_W = 36;

   // side information that travels beside the divide and root lanes
   typedef struct packed {
      logic       valid;
      logic       zero;
      logic [2:0] neg;
   } side_type;

endpackage

// ----- rtl/wnb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnb_req_if / wnb_rsp_if : request and response channels
// Valid/ready handshake; a request moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface wnb_req_if;
   logic                      valid;
   logic                      ready;
   logic [wnb_pkg::IN_W-1:0]  aperture_x_low;
   logic [wnb_pkg::IN_W-1:0]  aperture_x_high;
   logic [wnb_pkg::IN_W-1:0]  aperture_y_low;
   logic [wnb_pkg::IN_W-1:0]  aperture_y_high;
   logic [wnb_pkg::IN_W-1:0]  aperture_z_low;
   logic [wnb_pkg::IN_W-1:0]  aperture_z_high;

   modport source (output valid, aperture_x_low, aperture_x_high, aperture_y_low,
                   aperture_y_high, aperture_z_low, aperture_z_high, input ready);
   modport sink   (input valid, aperture_x_low, aperture_x_high, aperture_y_low,
                   aperture_y_high, aperture_z_low, aperture_z_high, output ready);
endinterface

interface wnb_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [wnb_pkg::NRM_W-1:0]  normal_x;
   logic signed [wnb_pkg::NRM_W-1:0]  normal_y;
   logic signed [wnb_pkg::NRM_W-1:0]  normal_z;
   logic signed [wnb_pkg::TAN_W-1:0]  tangent_a_x;
   logic signed [wnb_pkg::TAN_W-1:0]  tangent_a_y;
   logic signed [wnb_pkg::TAN_W-1:0]  tangent_a_z;
   logic signed [wnb_pkg::TAN_W-1:0]  tangent_b_x;
   logic signed [wnb_pkg::TAN_W-1:0]  tangent_b_y;
   logic signed [wnb_pkg::TAN_W-1:0]  tangent_b_z;
   logic                              zero_length;

   modport source (output valid, normal_x, normal_y, normal_z, tangent_a_x, tangent_a_y,
                   tangent_a_z, tangent_b_x, tangent_b_y, tangent_b_z, zero_length,
                   input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, tangent_a_x, tangent_a_y,
                   tangent_a_z, tangent_b_x, tangent_b_y, tangent_b_z, zero_length,
                   output ready);
endinterface

// ----- rtl/wall_normal_basis_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_normal_basis_core : unit wall normal and tangent frame per cut cell
// Normal = (low - high) / |low - high|, then two tangents in fixed point.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  req_bus   in         six aperture fractions, 17 bits unsigned
//  rsp_bus   out        normal, two tangents, zero-length flag
//
//  One request per cycle while the response is not stalled, fully pipelined.
//  The pipeline length is set mostly by the per-bit divide and root lanes.
//  Reset is synchronous and clears only the valid bits.
//  A stalled response freezes the whole pipeline; the input stage still takes
//  one request while it is empty.
// ----------------------------------------------------------------------------
module wall_normal_basis_core #(
   parameter int SPACE_DIMS = 3,
   parameter int FRAC_BITS  = 16
) (
   input  logic      clock,
   input  logic      reset,
   wnb_req_if.sink   req_bus,
   wnb_rsp_if.source rsp_bus
);
   localparam int F  = FRAC_BITS;
   localparam int QW = 2 * F + 3;
   localparam int TW = F + 2;
   localparam int NW = F + 2;
   localparam int DL = QW + TW;
   localparam int IW = wnb_pkg::IN_W;
   localparam int AW = wnb_pkg::AD_W;
   localparam int QSW = wnb_pkg::SQ_W;
   localparam int SW = wnb_pkg::SUM_W;

   logic advance, load0, frame_valid, frame_zero;
   logic v0_ff;
   logic signed [NW-1:0]  frame_n  [3];
   logic signed [F+2:0]   frame_ta [3];
   logic signed [F+2:0]   frame_tb [3];

   assign advance     = !frame_valid || rsp_bus.ready;
   assign load0       = advance || !v0_ff;
   assign req_bus.ready = load0;

   // stage 0: request register
   logic [IW-1:0] lo_ff [3];
   logic [IW-1:0] hi_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (load0) begin
         v0_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load0) begin
         lo_ff[0] <= req_bus.aperture_x_low;
         hi_ff[0] <= req_bus.aperture_x_high;
         lo_ff[1] <= req_bus.aperture_y_low;
         hi_ff[1] <= req_bus.aperture_y_high;
         lo_ff[2] <= req_bus.aperture_z_low;
         hi_ff[2] <= req_bus.aperture_z_high;
      end
   end

   // stage 1: differences as sign and magnitude
   logic          v1_ff;
   logic [2:0]    neg1_ff;
   logic [AW-1:0] ad1_ff [3];
   logic [2:0]    neg1_in;
   logic [AW-1:0] ad1_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         logic signed [IW:0] diff;
         diff = $signed({1'b0, lo_ff[i]}) - $signed({1'b0, hi_ff[i]});
         if (i >= SPACE_DIMS) begin
            diff = '0;
         end
         neg1_in[i] = diff[IW];
         ad1_in[i]  = diff[IW] ? AW'(-diff) : AW'(diff);
      end
   end

   // stage 2: squares; stage 3: sum of squares
   logic           v2_ff, v3_ff, z3_ff;
   logic [2:0]     neg2_ff, neg3_ff;
   logic [QSW-1:0] sq2_ff [3];
   logic [QSW-1:0] sq3_ff [3];
   logic [SW-1:0]  sum3_ff;
   logic [SW-1:0]  sum_in;

   assign sum_in = SW'(sq2_ff[0]) + SW'(sq2_ff[1]) + SW'(sq2_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg1_ff <= neg1_in;
         ad1_ff  <= ad1_in;
         neg2_ff <= neg1_ff;
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= ad1_ff[i] * ad1_ff[i];
         end
         neg3_ff <= neg2_ff;
         sq3_ff  <= sq2_ff;
         sum3_ff <= sum_in;
         z3_ff   <= sum_in == '0;
      end
   end

   // side line beside the divide and root lanes
   wnb_pkg::side_type side_ff [DL];

   for (genvar k = 0; k < DL; k++) begin : g_side
      wnb_pkg::side_type side_in;
      if (k == 0) begin : g_head
         assign side_in = '{valid: v3_ff, zero: z3_ff, neg: neg3_ff};
      end else begin : g_tail
         assign side_in = side_ff[k-1];
      end
      // reset drops the valid bit; the flags beside it are don't care
      always_ff @(posedge clock) begin
         if (reset || advance) begin
            side_ff[k] <= '{valid: side_in.valid && !reset, zero: side_in.zero,
                            neg: side_in.neg};
         end
      end
   end

   // one divide and root lane per component
   logic [QW-1:0] quo  [3];
   logic [TW-1:0] root [3];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      wnb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock    (clock),
         .advance  (advance),
         .square   (sq3_ff[i]),
         .total    (sum3_ff),
         .quotient (quo[i])
      );
      wnb_isqrt #(.FRAC_BITS(FRAC_BITS)) u_isqrt (
         .clock    (clock),
         .advance  (advance),
         .radicand (quo[i]),
         .root     (root[i])
      );
   end

   // stage N: round the root by half and restore the sign
   logic                 vn_ff, zn_ff;
   logic signed [NW-1:0] n_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
      end else if (advance) begin
         vn_ff <= side_ff[DL-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zn_ff <= side_ff[DL-1].zero;
         for (int i = 0; i < 3; i++) begin
            logic [TW:0] up;
            up = (TW + 1)'(root[i]) + (TW + 1)'(1);
            n_ff[i] <= side_ff[DL-1].neg[i] ? -$signed(NW'(up[TW:1]))
                                            : $signed(NW'(up[TW:1]));
         end
      end
   end

   wnb_frame #(.SPACE_DIMS(SPACE_DIMS), .FRAC_BITS(FRAC_BITS)) u_frame (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (vn_ff),
      .in_zero    (zn_ff),
      .in_normal  (n_ff),
      .out_valid  (frame_valid),
      .out_zero   (frame_zero),
      .out_normal (frame_n),
      .out_tan_a  (frame_ta),
      .out_tan_b  (frame_tb)
   );

   // response drive from the frame output register
   assign rsp_bus.valid       = frame_valid;
   assign rsp_bus.zero_length = frame_zero;
   assign rsp_bus.normal_x    = wnb_pkg::NRM_W'(frame_n[0]);
   assign rsp_bus.normal_y    = wnb_pkg::NRM_W'(frame_n[1]);
   assign rsp_bus.normal_z    = wnb_pkg::NRM_W'(frame_n[2]);
   assign rsp_bus.tangent_a_x = wnb_pkg::TAN_W'(frame_ta[0]);
   assign rsp_bus.tangent_a_y = wnb_pkg::TAN_W'(frame_ta[1]);
   assign rsp_bus.tangent_a_z = wnb_pkg::TAN_W'(frame_ta[2]);
   assign rsp_bus.tangent_b_x = wnb_pkg::TAN_W'(frame_tb[0]);
   assign rsp_bus.tangent_b_y = wnb_pkg::TAN_W'(frame_tb[1]);
   assign rsp_bus.tangent_b_z = wnb_pkg::TAN_W'(frame_tb[2]);

endmodule

// ----- rtl/wnb_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnb_div : pipelined restoring divider
// Quotient floor(square * 2^(2F+2) / total), one quotient bit per stage.
// ----------------------------------------------------------------------------
module wnb_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [wnb_pkg::SQ_W-1:0]      square,
   input  logic [wnb_pkg::SUM_W-1:0]     total,
   output logic [2*FRAC_BITS+2:0]        quotient
);
   localparam int QW = 2 * FRAC_BITS + 3;
   localparam int SW = wnb_pkg::SUM_W;

   logic [SW-1:0] rem_ff [QW];
   logic [SW-1:0] div_ff [QW];
   logic [QW-1:0] quo_ff [QW];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      logic [SW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (j == 0) begin : g_first
         // leading bit: the square never exceeds the total
         logic take;
         always_comb begin
            take   = SW'(square) >= total;
            rem_in = take ? SW'(square) - total : SW'(square);
            quo_in = QW'(take);
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[j] <= rem_in;
               div_ff[j] <= total;
               quo_ff[j] <= quo_in;
            end
         end
      end else begin : g_next
         // shift in a zero numerator bit, compare and subtract
         logic [SW:0] twice;
         logic        take;
         always_comb begin
            twice  = {rem_ff[j-1], 1'b0};
            take   = twice >= {1'b0, div_ff[j-1]};
            rem_in = take ? SW'(twice - {1'b0, div_ff[j-1]}) : SW'(twice);
            quo_in = {quo_ff[j-1][QW-2:0], take};
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[j] <= rem_in;
               div_ff[j] <= div_ff[j-1];
               quo_ff[j] <= quo_in;
            end
         end
      end
   end

   assign quotient = quo_ff[QW-1];

endmodule

// ----- rtl/wnb_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnb_isqrt : pipelined integer square root
// Floor square root of the quotient, one root bit per stage, MSB first.
// ----------------------------------------------------------------------------
module wnb_isqrt #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      advance,
   input  logic [2*FRAC_BITS+2:0]    radicand,
   output logic [FRAC_BITS+1:0]      root
);
   localparam int TW = FRAC_BITS + 2;
   localparam int RW = 2 * FRAC_BITS + 6;

   logic [RW-1:0] rem_ff  [TW];
   logic [TW-1:0] root_ff [TW];

   for (genvar k = 0; k < TW; k++) begin : g_stage
      localparam int B = TW - 1 - k;
      logic [RW-1:0] rem_prev;
      logic [TW-1:0] root_prev;
      logic [RW-1:0] trial;
      logic          take;

      if (k == 0) begin : g_first
         assign rem_prev  = RW'(radicand);
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      // (t + 2^b)^2 - t^2 = t*2^(b+1) + 2^(2b)
      always_comb begin
         trial = (RW'(root_prev) << (B + 1)) + (RW'(1) << (2 * B));
         take  = rem_prev >= trial;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= take ? rem_prev - trial : rem_prev;
            root_ff[k] <= take ? root_prev | (TW'(1) << B) : root_prev;
         end
      end
   end

   assign root = root_ff[TW-1];

endmodule

// ----- rtl/wnb_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnb_frame : tangent frame from the unit normal
// Four stages: first products, first tangent, cross products, second tangent.
// ----------------------------------------------------------------------------
module wnb_frame #(
   parameter int SPACE_DIMS = 3,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic                         in_zero,
   input  logic signed [FRAC_BITS+1:0]  in_normal [3],
   output logic                         out_valid,
   output logic                         out_zero,
   output logic signed [FRAC_BITS+1:0]  out_normal [3],
   output logic signed [FRAC_BITS+2:0]  out_tan_a [3],
   output logic signed [FRAC_BITS+2:0]  out_tan_b [3]
);
   localparam int F   = FRAC_BITS;
   localparam int NW  = F + 2;
   localparam int HW  = F + 3;
   localparam int TW  = F + 3;
   localparam int AW  = 2 * F + 6;
   localparam logic signed [HW-1:0] ONE_H  = HW'(1) <<< F;
   localparam logic signed [AW-1:0] HALF_A = AW'(1) <<< (F - 1);

   // stage A: products of the normal
   logic                   va_ff, za_ff;
   logic signed [NW-1:0]   na_ff [3];
   logic signed [HW-1:0]   gh_ff;
   logic signed [2*NW-1:0] pxx_ff, pxy_ff;
   logic signed [NW+HW-1:0] pxh_ff;
   logic signed [HW-1:0]   h_in, gh_in;

   always_comb begin
      h_in  = in_normal[2][NW-1] ? HW'(in_normal[2]) - ONE_H : HW'(in_normal[2]) + ONE_H;
      gh_in = in_normal[2][NW-1] ? -h_in : h_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         za_ff  <= in_zero;
         na_ff  <= in_normal;
         gh_ff  <= gh_in;
         pxx_ff <= in_normal[0] * in_normal[0];
         pxy_ff <= in_normal[0] * in_normal[1];
         pxh_ff <= in_normal[0] * h_in;
      end
   end

   // stage B: first tangent; in three dimensions rounded to nearest, ties upward
   logic                 vb_ff, zb_ff;
   logic signed [NW-1:0] nb_ff [3];
   logic signed [TW-1:0] tab_ff [3];
   logic signed [TW-1:0] ta_in [3];

   if (SPACE_DIMS == 2) begin : g_flat
      always_comb begin
         ta_in[0] = -TW'(na_ff[1]);
         ta_in[1] = TW'(na_ff[0]);
         ta_in[2] = '0;
      end
   end else begin : g_solid
      always_comb begin
         ta_in[0] = TW'(((AW'(gh_ff) <<< F) - AW'(pxx_ff) + HALF_A) >>> F);
         ta_in[1] = TW'((-AW'(pxy_ff) + HALF_A) >>> F);
         ta_in[2] = TW'((-AW'(pxh_ff) + HALF_A) >>> F);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (advance) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zb_ff  <= za_ff;
         nb_ff  <= na_ff;
         tab_ff <= ta_in;
      end
   end

   // stage C: cross product terms
   logic                    vc_ff, zc_ff;
   logic signed [NW-1:0]    nc_ff [3];
   logic signed [TW-1:0]    tac_ff [3];
   logic signed [NW+TW-1:0] pp_ff [3];
   logic signed [NW+TW-1:0] pm_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (advance) begin
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zc_ff    <= zb_ff;
         nc_ff    <= nb_ff;
         tac_ff   <= tab_ff;
         pp_ff[0] <= nb_ff[1] * tab_ff[2];
         pm_ff[0] <= nb_ff[2] * tab_ff[1];
         pp_ff[1] <= nb_ff[2] * tab_ff[0];
         pm_ff[1] <= nb_ff[0] * tab_ff[2];
         pp_ff[2] <= nb_ff[0] * tab_ff[1];
         pm_ff[2] <= nb_ff[1] * tab_ff[0];
      end
   end

   // stage D: second tangent, zero-length results forced to zero
   logic                 vd_ff, zd_ff;
   logic signed [NW-1:0] nd_ff [3];
   logic signed [TW-1:0] tad_ff [3];
   logic signed [TW-1:0] tbd_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (advance) begin
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         zd_ff <= zc_ff;
         for (int i = 0; i < 3; i++) begin
            nd_ff[i]  <= zc_ff ? '0 : nc_ff[i];
            tad_ff[i] <= zc_ff ? '0 : tac_ff[i];
            tbd_ff[i] <= zc_ff ? '0
                       : TW'((AW'(pp_ff[i]) - AW'(pm_ff[i]) + HALF_A) >>> F);
         end
      end
   end

   assign out_valid  = vd_ff;
   assign out_zero   = zd_ff;
   assign out_normal = nd_ff;
   assign out_tan_a  = tad_ff;
   assign out_tan_b  = tbd_ff;

endmodule

// ----- tb/tb_wall_normal_basis_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wall_normal_basis_core : self-checking bench for the wall normal core
// Drives directed and random aperture requests with random gaps on both
// sides, predicts the unit normal and tangent frame in fixed point and
// compares every response field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_wall_normal_basis_core;

   localparam int DIMS  = 3;
   localparam int FB    = 16;
   localparam int N_RND = 400;
   localparam int LIMIT = 400000;

   typedef struct {
      logic [wnb_pkg::IN_W-1:0] ap [6];
   } aperture_set_type;

   typedef struct {
      logic signed [wnb_pkg::NRM_W-1:0] nrm [3];
      logic signed [wnb_pkg::TAN_W-1:0] ta  [3];
      logic signed [wnb_pkg::TAN_W-1:0] tb  [3];
      logic                             zero;
   } frame_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   wnb_req_if req_bus ();
   wnb_rsp_if rsp_bus ();

   frame_type frame_queue [$];
   int     n_errors = 0;
   int     n_checked = 0;
   int     n_zero = 0;
   longint cycles = 0;
   bit     stim_done = 1'b0;

   wall_normal_basis_core #(.SPACE_DIMS(DIMS), .FRAC_BITS(FB)) uut (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus));

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_wall_normal_basis_core: errors");
         $finish;
      end
   end

   // nearest |d|*2^F/sqrt(s), ties away from zero
   function automatic longint unit_component(longint d, longint unsigned s);
      longint unsigned ad;
      bit [127:0]      rhs;
      bit [127:0]      lhs;
      longint unsigned t;
      longint unsigned c;
      longint          mag;
      ad  = (d < 0) ? -d : d;
      rhs = 128'(ad * ad) << (2 * FB + 2);
      t   = 0;
      for (int b = FB + 1; b >= 0; b--) begin
         c   = t | (64'd1 << b);
         lhs = 128'(c * c) * 128'(s);
         if (lhs <= rhs) t = c;
      end
      mag = longint'((t + 1) >> 1);
      return (d < 0) ? -mag : mag;
   endfunction

   // 2F to F fraction bits, nearest, ties toward +inf
   function automatic longint round_half_up(longint v);
      return (v + (longint'(1) << (FB - 1))) >>> FB;
   endfunction

   function automatic frame_type predict_frame(aperture_set_type a);
      frame_type       f;
      longint          d [3];
      longint          n [3];
      longint          ta [3];
      longint          tb [3];
      longint unsigned s;
      longint          one;
      longint          h;
      longint          gh;
      one = longint'(1) << FB;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = (i < DIMS) ? longint'(a.ap[2*i]) - longint'(a.ap[2*i+1]) : 0;
         s += d[i] * d[i];
      end
      for (int i = 0; i < 3; i++) begin
         f.nrm[i] = '0;
         f.ta[i]  = '0;
         f.tb[i]  = '0;
      end
      f.zero = (s == 0);
      if (f.zero) return f;
      for (int i = 0; i < 3; i++) n[i] = (d[i] == 0) ? 0 : unit_component(d[i], s);
      if (DIMS == 2) begin
         ta[0] = -n[1];
         ta[1] = n[0];
         ta[2] = 0;
      end else begin
         h  = (n[2] < 0) ? n[2] - one : n[2] + one;
         gh = (n[2] < 0) ? -h : h;
         ta[0] = round_half_up(gh * one - n[0] * n[0]);
         ta[1] = round_half_up(-(n[0] * n[1]));
         ta[2] = round_half_up(-(n[0] * h));
      end
      tb[0] = round_half_up(n[1] * ta[2] - n[2] * ta[1]);
      tb[1] = round_half_up(n[2] * ta[0] - n[0] * ta[2]);
      tb[2] = round_half_up(n[0] * ta[1] - n[1] * ta[0]);
      for (int i = 0; i < 3; i++) begin
         f.nrm[i] = n[i][wnb_pkg::NRM_W-1:0];
         f.ta[i]  = ta[i][wnb_pkg::TAN_W-1:0];
         f.tb[i]  = tb[i][wnb_pkg::TAN_W-1:0];
      end
      return f;
   endfunction

   // typed expectations: rows 0 and 1 cancel out, row 2 is the unit x normal
   function automatic frame_type typed_frame(int row);
      frame_type f;
      for (int i = 0; i < 3; i++) begin
         f.nrm[i] = '0;
         f.ta[i]  = '0;
         f.tb[i]  = '0;
      end
      f.zero = (row < 2);
      if (row == 2) begin
         f.nrm[0] = 18'sd65536;
         f.ta[2]  = -19'sd65536;
         f.tb[1]  = 19'sd65536;
      end
      return f;
   endfunction

   task automatic send_request(aperture_set_type a, frame_type e);
      int gap;
      gap = $urandom_range(0, 11);
      repeat (gap) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.aperture_x_low  <= a.ap[0];
      req_bus.aperture_x_high <= a.ap[1];
      req_bus.aperture_y_low  <= a.ap[2];
      req_bus.aperture_y_high <= a.ap[3];
      req_bus.aperture_z_low  <= a.ap[4];
      req_bus.aperture_z_high <= a.ap[5];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      frame_queue.push_back(e);
      @(negedge clock);
   endtask

   function automatic logic [wnb_pkg::IN_W-1:0] random_aperture();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 17'd65536;
         2: return 17'h1FFFF;
         3: return wnb_pkg::IN_W'($urandom_range(65500, 65536));
         default: return wnb_pkg::IN_W'($urandom);
      endcase
   endfunction

   // directed rows: x0l x0h y0l y0h z0l z0h
   int directed_rows [20][6] = '{
      '{0, 0, 0, 0, 0, 0},
      '{65536, 65536, 123, 123, 'h1FFFF, 'h1FFFF},
      '{65536, 0, 0, 0, 0, 0},
      '{0, 65536, 0, 0, 0, 0},
      '{0, 0, 65536, 0, 0, 0},
      '{0, 0, 0, 65536, 0, 0},
      '{0, 0, 0, 0, 65536, 0},
      '{0, 0, 0, 0, 0, 65536},
      '{65536, 0, 65536, 0, 65536, 0},
      '{0, 65536, 0, 65536, 0, 65536},
      '{'h1FFFF, 0, 0, 'h1FFFF, 0, 0},
      '{'h1FFFF, 0, 'h1FFFF, 0, 0, 'h1FFFF},
      '{1, 0, 0, 0, 0, 0},
      '{0, 1, 1, 0, 0, 0},
      '{1, 0, 1, 0, 1, 0},
      '{32768, 0, 0, 32768, 5, 5},
      '{0, 0, 0, 0, 'h1FFFF, 'h1FFFE},
      '{'h15555, 'h0AAAA, 'h0AAAA, 'h15555, 'h10000, 'h00001},
      '{40000, 10000, 20000, 50000, 30000, 30000},
      '{0, 40000, 30000, 0, 0, 0}};

   // stimulus
   initial begin
      aperture_set_type a;
      req_bus.valid           = 1'b0;
      req_bus.aperture_x_low  = '0;
      req_bus.aperture_x_high = '0;
      req_bus.aperture_y_low  = '0;
      req_bus.aperture_y_high = '0;
      req_bus.aperture_z_low  = '0;
      req_bus.aperture_z_high = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int r = 0; r < 20; r++) begin
         for (int k = 0; k < 6; k++) a.ap[k] = wnb_pkg::IN_W'(directed_rows[r][k]);
         if (r < 3) begin
            send_request(a, typed_frame(r));
         end else begin
            send_request(a, predict_frame(a));
         end
      end
      for (int r = 0; r < N_RND; r++) begin
         for (int k = 0; k < 6; k++) a.ap[k] = random_aperture();
         // sometimes a matching pair so some dimensions cancel
         if ($urandom_range(0, 7) == 0) a.ap[1] = a.ap[0];
         if ($urandom_range(0, 7) == 0) a.ap[5] = a.ap[4];
         send_request(a, predict_frame(a));
      end
      req_bus.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // response ready with random stalls
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // response checker
   always @(posedge clock) begin
      frame_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (frame_queue.size() == 0) begin
            $error("response with no request outstanding");
            n_errors++;
         end else begin
            e = frame_queue.pop_front();
            n_checked++;
            if (e.zero) n_zero++;
            if (rsp_bus.zero_length !== e.zero) begin
               $error("zero_length exp %0d got %0d", e.zero, rsp_bus.zero_length);
               n_errors++;
            end
            if (rsp_bus.normal_x !== e.nrm[0]) begin
               $error("normal_x exp %0d got %0d", e.nrm[0], rsp_bus.normal_x);
               n_errors++;
            end
            if (rsp_bus.normal_y !== e.nrm[1]) begin
               $error("normal_y exp %0d got %0d", e.nrm[1], rsp_bus.normal_y);
               n_errors++;
            end
            if (rsp_bus.normal_z !== e.nrm[2]) begin
               $error("normal_z exp %0d got %0d", e.nrm[2], rsp_bus.normal_z);
               n_errors++;
            end
            if (rsp_bus.tangent_a_x !== e.ta[0]) begin
               $error("tangent_a_x exp %0d got %0d", e.ta[0], rsp_bus.tangent_a_x);
               n_errors++;
            end
            if (rsp_bus.tangent_a_y !== e.ta[1]) begin
               $error("tangent_a_y exp %0d got %0d", e.ta[1], rsp_bus.tangent_a_y);
               n_errors++;
            end
            if (rsp_bus.tangent_a_z !== e.ta[2]) begin
               $error("tangent_a_z exp %0d got %0d", e.ta[2], rsp_bus.tangent_a_z);
               n_errors++;
            end
            if (rsp_bus.tangent_b_x !== e.tb[0]) begin
               $error("tangent_b_x exp %0d got %0d", e.tb[0], rsp_bus.tangent_b_x);
               n_errors++;
            end
            if (rsp_bus.tangent_b_y !== e.tb[1]) begin
               $error("tangent_b_y exp %0d got %0d", e.tb[1], rsp_bus.tangent_b_y);
               n_errors++;
            end
            if (rsp_bus.tangent_b_z !== e.tb[2]) begin
               $error("tangent_b_z exp %0d got %0d", e.tb[2], rsp_bus.tangent_b_z);
               n_errors++;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (frame_queue.size() != 0) @(posedge clock);
      repeat (3 * FB + 30) @(posedge clock);
      $display("checked %0d frames, %0d of them zero length, with gaps and stalls",
               n_checked, n_zero);
      if (n_errors == 0) begin
         $display("tb_wall_normal_basis_core: clean");
      end else begin
         $display("tb_wall_normal_basis_core: errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/wnb_pkg.sv
rtl/wnb_if.sv
rtl/wnb_div.sv
rtl/wnb_isqrt.sv
rtl/wnb_frame.sv
rtl/wall_normal_basis_core.sv
tb/tb_wall_normal_basis_core.sv
